FILE: hw/rtl/dq_pkg.sv
// shared types and constants of the double-ended queue
// operation codes, result status codes and the command passed from front to back
// no dependencies
package dq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int RESULT_LIMIT  = 16;
  localparam int CMDQ_DEPTH    = 2;
  localparam int VALUE_W       = 32;
  localparam int KIND_W        = 3;
  localparam int STATUS_W      = 2;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

FILE: hw/rtl/dq_front.sv
// front end of the double-ended queue: accepts input transfers and decodes the kind
// unknown kinds are consumed and dropped; depends on dq_pkg
module dq_front (
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dq_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [dq_pkg::VALUE_W-1:0]  in_value,
  input  logic                               q_full,
  output logic                               q_push,
  output dq_pkg::cmd_t                       q_cmd
);

  logic known;

  always_comb begin
    known    = 1'b1;
    q_cmd.op = dq_pkg::OP_PUSH_FRONT;
    unique case (in_kind)
      dq_pkg::OP_PUSH_FRONT: q_cmd.op = dq_pkg::OP_PUSH_FRONT;
      dq_pkg::OP_PUSH_BACK:  q_cmd.op = dq_pkg::OP_PUSH_BACK;
      dq_pkg::OP_POP_FRONT:  q_cmd.op = dq_pkg::OP_POP_FRONT;
      dq_pkg::OP_POP_BACK:   q_cmd.op = dq_pkg::OP_POP_BACK;
      dq_pkg::OP_DUMP:       q_cmd.op = dq_pkg::OP_DUMP;
      default:               known    = 1'b0;
    endcase
    q_cmd.value = in_value;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && known;

endmodule

FILE: hw/rtl/dq_cmdq.sv
// short command queue between front and back of the double-ended queue
// register-based fifo of decoded commands; depends on dq_pkg
module dq_cmdq (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  dq_pkg::cmd_t push_cmd,
  output logic         full,
  output logic         pop_valid,
  input  logic         pop_take,
  output dq_pkg::cmd_t pop_cmd
);

  localparam int QD    = dq_pkg::CMDQ_DEPTH;
  localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNT_W = $clog2(QD + 1);

  dq_pkg::cmd_t     q_r [QD];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign full      = (cnt_r == CNT_W'(QD));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = q_r[rd_ptr_r];
  assign do_pop    = pop_valid && pop_take;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/dq_back.sv
// back end of the double-ended queue: ring store, front pointer, count and result register
// executes one command at a time; depends on dq_pkg
module dq_back #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_valid,
  output logic                               cmd_take,
  input  dq_pkg::cmd_t                       cmd,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dq_pkg::VALUE_W-1:0]  out_value_res,
  output logic [dq_pkg::STATUS_W-1:0]        out_status,
  output logic                               out_last
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = CNT_W + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] off_r, off_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [dq_pkg::VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [dq_pkg::STATUS_W-1:0]        out_status_r, out_status_nxt;
  logic                               out_last_r, out_last_nxt;

  logic signed [dq_pkg::VALUE_W-1:0]  mem [DEPTH];
  logic signed [dq_pkg::VALUE_W-1:0]  rd_data_r;
  logic [IDX_W-1:0]                   rd_addr;
  logic [IDX_W-1:0]                   wr_addr;
  logic                               wr_en;

  logic             out_free;
  logic             is_full;
  logic             is_empty;
  logic [CMP_W-1:0] off_plus;
  logic             dump_last;
  logic [IDX_W-1:0] front_dec;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = (IDX_W+1)'(base) + (IDX_W+1)'(off);
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign off_plus  = CMP_W'(off_r) + 1'b1;
  assign dump_last = (off_plus == CMP_W'(count_r)) ||
                     (off_plus == CMP_W'(dq_pkg::RESULT_LIMIT));
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
  assign cmd_take  = (state_r == S_IDLE) && cmd_valid && out_free;
  assign rd_addr   = slot_of(front_r, off_nxt);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    off_nxt        = off_r;
    wr_en          = 1'b0;
    wr_addr        = front_dec;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_take) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = dq_pkg::ST_OK;
          out_last_nxt   = 1'b1;
          unique case (cmd.op)
            dq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                out_status_nxt = dq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            dq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                out_status_nxt = dq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = slot_of(front_r, IDX_W'(count_r));
                count_nxt = count_r + 1'b1;
              end
            end
            dq_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                out_status_nxt = dq_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                off_nxt       = '0;
                front_nxt     = slot_of(front_r, IDX_W'(1));
                count_nxt     = count_r - 1'b1;
                state_nxt     = S_POP;
              end
            end
            dq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                out_status_nxt = dq_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                off_nxt       = IDX_W'(count_r - 1'b1);
                count_nxt     = count_r - 1'b1;
                state_nxt     = S_POP;
              end
            end
            dq_pkg::OP_DUMP: begin
              if (is_empty) begin
                out_status_nxt = dq_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                off_nxt       = '0;
                state_nxt     = S_DUMP;
              end
            end
            default: out_valid_nxt = 1'b0;
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_data_r;
          out_status_nxt = dq_pkg::ST_OK;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_data_r;
          out_status_nxt = dq_pkg::ST_OK;
          out_last_nxt   = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            off_nxt = off_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // ring store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

endmodule

FILE: hw/rtl/double_ended_queue.sv
// top level of the double-ended queue: front decoder, command queue and back end
// depends on dq_pkg, dq_front, dq_cmdq and dq_back
//
// usage:
//   input channel in_valid/in_stall carries in_kind and in_value; a transfer happens
//   on a clock edge with in_valid high and in_stall low. kinds: push front, push back,
//   pop front, pop back, dump all; other kinds are taken and dropped without a result.
//   result channel out_valid/out_stall carries out_value_res, out_status, out_last.
//   a push or pop gives one result; a dump gives one result per stored entry, front to
//   back, at most sixteen, with out_last on the final one; an empty queue gives status
//   empty, a push into a full queue is dropped with status full.
//   path: an input transfer is written into the command queue, the back end takes it and
//   registers the result; a pop or dump result also passes the registered ring store read.
//   the back end runs one command at a time and takes no new command until a pop or dump
//   has emitted its last result.
//   a two-entry command queue lets input transfers continue while the back end is busy.
//   reset (rst_n low, synchronous) empties the queue and clears all handshake state;
//   store contents are not cleared.
//   while out_stall and out_valid are high the result register holds and the back end waits; input
//   transfers go on until the command queue fills and in_stall rises.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dq_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [dq_pkg::VALUE_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dq_pkg::VALUE_W-1:0]  out_value_res,
  output logic [dq_pkg::STATUS_W-1:0]        out_status,
  output logic                               out_last
);

  logic         q_full;
  logic         q_push;
  dq_pkg::cmd_t q_cmd;
  logic         cmd_valid;
  logic         cmd_take;
  dq_pkg::cmd_t cmd;

  dq_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  dq_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop_valid (cmd_valid),
    .pop_take  (cmd_take),
    .pop_cmd   (cmd)
  );

  dq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_take      (cmd_take),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value_res (out_value_res),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule
